FILE: sv/fxalu_pkg.sv
// ----------------------------------------------------------------------------
// fxalu_pkg: shared types and constants for the fixed-point ALU
// Operation codes, the context that travels alongside each request, and
// the widths of the division chain.
// ----------------------------------------------------------------------------
package fxalu_pkg;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_MIN     = 4'd4,
    OP_MAX     = 4'd5,
    OP_INC     = 4'd6,
    OP_DEC     = 4'd7,
    OP_CMP     = 4'd8,
    OP_TOINT   = 4'd9,
    OP_FROMINT = 4'd10
  } op_t;

  // Quotient bits produced by the chain; also the remainder and divisor width.
  localparam int QW = 33;

  // Per-request context carried beside the division data.
  typedef struct packed {
    logic        is_div;  // result comes from the chain quotient
    logic        neg;     // quotient sign
    logic        dovf;    // quotient known to be too large before the chain
    logic [31:0] res;     // finished result of every other operation
    logic        ovf;
    logic        dbz;
    logic        gt;
    logic        lt;
    logic        eq;
  } ctx_t;

endpackage

FILE: sv/fxalu_div_cell.sv
// ----------------------------------------------------------------------------
// fxalu_div_cell: one step of the restoring division chain
// Brings down one dividend bit, trial-subtracts the divisor and registers
// the new remainder, quotient and request context for the next cell.
// ----------------------------------------------------------------------------
module fxalu_div_cell #(
  parameter int NW  = 42,
  parameter int BIT = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  fxalu_pkg::ctx_t           in_ctx,
  input  logic [NW-1:0]             in_num,
  input  logic [fxalu_pkg::QW-1:0]  in_den,
  input  logic [fxalu_pkg::QW-1:0]  in_rem,
  input  logic [fxalu_pkg::QW-1:0]  in_quo,
  output logic                      out_valid,
  output fxalu_pkg::ctx_t           out_ctx,
  output logic [NW-1:0]             out_num,
  output logic [fxalu_pkg::QW-1:0]  out_den,
  output logic [fxalu_pkg::QW-1:0]  out_rem,
  output logic [fxalu_pkg::QW-1:0]  out_quo
);

  logic [fxalu_pkg::QW:0]   trial;
  logic                     take;
  logic [fxalu_pkg::QW-1:0] rem_next;

  always_comb begin
    trial    = {in_rem, in_num[BIT]};
    take     = (trial >= {1'b0, in_den});
    rem_next = take ? fxalu_pkg::QW'(trial - {1'b0, in_den})
                    : trial[fxalu_pkg::QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_ctx <= in_ctx;
    out_num <= in_num;
    out_den <= in_den;
    out_rem <= rem_next;
    out_quo <= {in_quo[fxalu_pkg::QW-2:0], take};
  end

endmodule

FILE: sv/fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu: signed fixed-point ALU with saturation
// Add, subtract, multiply, divide, min, max, increment, decrement, compare
// and integer conversions on raw signed 32-bit fixed-point values.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge at which start is high; busy is
// never raised, so one request may be issued per cycle indefinitely. Each
// request produces exactly one result, shown for a single cycle with done
// high, and results leave in request order. The receiver cannot stall the
// block, so it must capture the result on the cycle that done is high. Each
// result passes through the division chain: one cell per quotient bit, 33
// cells, preceded by an input register (loaded on the taking edge itself),
// an operand stage holding the 32 by 32 multiplier and a rounding stage, and
// followed by the output register. Every operation follows the same path so
// that results never overtake one another. Multiply and divide round to
// nearest with ties away from zero; any result beyond the signed 32-bit range
// saturates and raises overflow. Division by zero returns zero with
// divide_by_zero set. The comparison flags always compare operand_a with
// operand_b.
module fixed_point_q24_8_alu #(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         req_type,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               done,
  output logic signed [31:0] result,
  output logic               a_greater,
  output logic               a_less,
  output logic               a_equal,
  output logic               overflow,
  output logic               divide_by_zero
);

  localparam int QW  = fxalu_pkg::QW;
  // Dividend 2*(|a| << F) + |b| fits in this many bits.
  localparam int NW  = FRACTION_BITS + 34;
  localparam int LAT = QW + 4;

  localparam logic signed [63:0] MAXV = 64'sd2147483647;
  localparam logic signed [63:0] MINV = -64'sd2147483648;

  // Input register.
  logic               v0;
  logic [3:0]         op0;
  logic signed [31:0] a0;
  logic signed [31:0] b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    op0 <= req_type;
    a0  <= operand_a;
    b0  <= operand_b;
  end

  assign busy = 1'b0;

  // Operand stage: magnitudes, the multiplier and every simple operation.
  logic [31:0]        ma;
  logic [31:0]        mb;
  logic signed [32:0] sum;
  logic signed [32:0] dif;
  logic signed [63:0] shl;
  fxalu_pkg::ctx_t    ctx1_next;
  logic [NW-1:0]      num1_next;

  always_comb begin
    ma  = a0[31] ? 32'(-a0) : 32'(a0);
    mb  = b0[31] ? 32'(-b0) : 32'(b0);
    sum = 33'(a0) + 33'(b0);
    dif = 33'(a0) - 33'(b0);
    shl = 64'(a0) <<< FRACTION_BITS;

    ctx1_next        = '0;
    ctx1_next.gt     = (a0 > b0);
    ctx1_next.lt     = (a0 < b0);
    ctx1_next.eq     = (a0 == b0);
    ctx1_next.neg    = a0[31] ^ b0[31];
    ctx1_next.is_div = (op0 == fxalu_pkg::OP_DIV) && (b0 != '0);
    ctx1_next.dbz    = (op0 == fxalu_pkg::OP_DIV) && (b0 == '0);

    unique case (op0)
      fxalu_pkg::OP_ADD: begin
        ctx1_next.ovf = sum[32] != sum[31];
        ctx1_next.res = ctx1_next.ovf ? {sum[32], {31{~sum[32]}}} : sum[31:0];
      end
      fxalu_pkg::OP_SUB: begin
        ctx1_next.ovf = dif[32] != dif[31];
        ctx1_next.res = ctx1_next.ovf ? {dif[32], {31{~dif[32]}}} : dif[31:0];
      end
      fxalu_pkg::OP_MIN: ctx1_next.res = (a0 < b0) ? a0 : b0;
      fxalu_pkg::OP_MAX: ctx1_next.res = (a0 >= b0) ? a0 : b0;
      fxalu_pkg::OP_INC: begin
        ctx1_next.ovf = (a0 == 32'sh7fffffff);
        ctx1_next.res = ctx1_next.ovf ? a0 : 32'(a0 + 32'sd1);
      end
      fxalu_pkg::OP_DEC: begin
        ctx1_next.ovf = (a0 == 32'sh80000000);
        ctx1_next.res = ctx1_next.ovf ? a0 : 32'(a0 - 32'sd1);
      end
      fxalu_pkg::OP_TOINT: ctx1_next.res = 32'(a0 >>> FRACTION_BITS);
      fxalu_pkg::OP_FROMINT: begin
        ctx1_next.ovf = (shl > MAXV) || (shl < MINV);
        ctx1_next.res = (shl > MAXV) ? 32'sh7fffffff :
                        (shl < MINV) ? 32'sh80000000 : shl[31:0];
      end
      default: ctx1_next.res = '0;
    endcase

    num1_next = (NW'(ma) << (FRACTION_BITS + 1)) + NW'(mb);
  end

  logic            v1;
  logic [3:0]      op1;
  fxalu_pkg::ctx_t ctx1;
  logic [63:0]     prod1;
  logic [NW-1:0]   num1;
  logic [QW-1:0]   den1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    op1   <= op0;
    ctx1  <= ctx1_next;
    prod1 <= 64'(ma) * 64'(mb);
    num1  <= num1_next;
    den1  <= {mb, 1'b0};
  end

  // Rounding stage: finish the product and check the quotient's top bits.
  logic [63:0]     pr;
  logic [63:0]     qm;
  logic [63:0]     top;
  fxalu_pkg::ctx_t ctx2_next;

  always_comb begin
    pr        = prod1 + (64'd1 << (FRACTION_BITS - 1));
    qm        = pr >> FRACTION_BITS;
    top       = 64'(num1) >> QW;
    ctx2_next = ctx1;
    ctx2_next.dovf = (top >= 64'(den1));
    if (op1 == fxalu_pkg::OP_MUL) begin
      if (!ctx1.neg && qm > 64'd2147483647) begin
        ctx2_next.ovf = 1'b1;
        ctx2_next.res = 32'sh7fffffff;
      end else if (ctx1.neg && qm > 64'd2147483648) begin
        ctx2_next.ovf = 1'b1;
        ctx2_next.res = 32'sh80000000;
      end else begin
        ctx2_next.res = ctx1.neg ? 32'(-qm[31:0]) : qm[31:0];
      end
    end
  end

  // Division chain: cell k handles quotient bit QW-1-k.
  logic            cv   [0:QW];
  fxalu_pkg::ctx_t cctx [0:QW];
  logic [NW-1:0]   cnum [0:QW];
  logic [QW-1:0]   cden [0:QW];
  logic [QW-1:0]   crem [0:QW];
  logic [QW-1:0]   cquo [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= v1;
    end
    cctx[0] <= ctx2_next;
    cnum[0] <= num1;
    cden[0] <= den1;
    crem[0] <= top[QW-1:0];
    cquo[0] <= '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_cell
    fxalu_div_cell #(
      .NW  (NW),
      .BIT (QW - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[k]),
      .in_ctx    (cctx[k]),
      .in_num    (cnum[k]),
      .in_den    (cden[k]),
      .in_rem    (crem[k]),
      .in_quo    (cquo[k]),
      .out_valid (cv[k+1]),
      .out_ctx   (cctx[k+1]),
      .out_num   (cnum[k+1]),
      .out_den   (cden[k+1]),
      .out_rem   (crem[k+1]),
      .out_quo   (cquo[k+1])
    );
  end

  // Output stage: apply sign and saturation to the quotient.
  fxalu_pkg::ctx_t fin;
  logic [QW-1:0]   q;
  logic            qbig;
  logic [31:0]     res_next;
  logic            ovf_next;

  always_comb begin
    fin      = cctx[QW];
    q        = cquo[QW];
    qbig     = fin.dovf || (fin.neg ? (q > 33'h080000000) : (q > 33'h07fffffff));
    res_next = fin.res;
    ovf_next = fin.ovf;
    if (fin.is_div) begin
      ovf_next = qbig;
      if (qbig) begin
        res_next = fin.neg ? 32'h80000000 : 32'h7fffffff;
      end else begin
        res_next = fin.neg ? 32'(-q[31:0]) : q[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cv[QW];
    end
    result         <= res_next;
    overflow       <= ovf_next;
    divide_by_zero <= fin.dbz;
    a_greater      <= fin.gt;
    a_less         <= fin.lt;
    a_equal        <= fin.eq;
  end

  // Every result corresponds to a request taken a fixed latency earlier.
  a_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT)) else $error("result without matching request");

  a_flags : assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot({a_greater, a_less, a_equal})) else $error("flags not exclusive");

  a_dbz : assert property (@(posedge clk) disable iff (rst)
    (done && divide_by_zero) |-> (result == '0 && !overflow))
    else $error("divide by zero result wrong");

  a_sat : assert property (@(posedge clk) disable iff (rst)
    (done && overflow) |-> (result == 32'sh7fffffff || result == 32'sh80000000))
    else $error("overflow without saturated result");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Q24.8 fixed-point ALU
// Drives a table of directed requests, then bursts of random requests, and
// compares every result against an integer model of the ALU in request order.
// ----------------------------------------------------------------------------
module tb;

  localparam int FRAC = 8;
  localparam int LATENCY = 36;
  localparam int N_RANDOM = 1430;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN = 32'h8000_0000;

  // One expected result; the flags are packed in the order of the ports.
  typedef struct packed {
    logic [31:0] value;
    logic        gt;
    logic        lt;
    logic        eq;
    logic        ovf;
    logic        dbz;
  } alu_out_t;

  // A directed row: the typed-in answer is used only when known is set.
  typedef struct {
    logic [3:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    bit          known;
    alu_out_t    answer;
  } vec_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [3:0] req_type;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  logic done;
  logic signed [31:0] result;
  logic a_greater, a_less, a_equal, overflow, divide_by_zero;

  alu_out_t pending_results[$];
  int errors;
  int checked;
  int cycles;
  int sent;

  fixed_point_q24_8_alu #(.FRACTION_BITS(FRAC)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .operand_a(operand_a), .operand_b(operand_b),
    .done(done), .result(result), .a_greater(a_greater), .a_less(a_less),
    .a_equal(a_equal), .overflow(overflow), .divide_by_zero(divide_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic [31:0] saturate(input logic signed [71:0] v,
                                           inout logic ovf);
    if (v > $signed(72'sh7FFF_FFFF)) begin
      ovf = 1'b1;
      return S_MAX;
    end
    if (v < -$signed(72'sh8000_0000)) begin
      ovf = 1'b1;
      return S_MIN;
    end
    return v[31:0];
  endfunction

  // Integer model of one ALU request.
  function automatic alu_out_t alu_predict(input logic [3:0] op,
                                           input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    alu_out_t o;
    logic signed [71:0] wa, wb, w;
    logic [71:0] ma, mb, q;
    logic neg;
    o = '0;
    wa = a;
    wb = b;
    ma = (a < 0) ? -wa : wa;
    mb = (b < 0) ? -wb : wb;
    neg = (a < 0) != (b < 0);
    case (op)
      fxalu_pkg::OP_ADD: o.value = saturate(wa + wb, o.ovf);
      fxalu_pkg::OP_SUB: o.value = saturate(wa - wb, o.ovf);
      fxalu_pkg::OP_MUL: begin
        q = (ma * mb + (72'd1 << (FRAC - 1))) >> FRAC;
        w = neg ? -$signed(q) : $signed(q);
        o.value = saturate(w, o.ovf);
      end
      fxalu_pkg::OP_DIV: begin
        if (b == 0) begin
          o.dbz = 1'b1;
        end else begin
          q = (2 * (ma << FRAC) + mb) / (2 * mb);
          w = neg ? -$signed(q) : $signed(q);
          o.value = saturate(w, o.ovf);
        end
      end
      fxalu_pkg::OP_MIN: o.value = (a < b) ? a : b;
      fxalu_pkg::OP_MAX: o.value = (a >= b) ? a : b;
      fxalu_pkg::OP_INC: o.value = saturate(wa + 1, o.ovf);
      fxalu_pkg::OP_DEC: o.value = saturate(wa - 1, o.ovf);
      fxalu_pkg::OP_TOINT: o.value = a >>> FRAC;
      fxalu_pkg::OP_FROMINT: o.value = saturate(wa <<< FRAC, o.ovf);
      default: o.value = '0;
    endcase
    o.gt = a > b;
    o.lt = a < b;
    o.eq = a == b;
    return o;
  endfunction

  // Operand with a bias towards the edges of the range and small values.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return S_MAX - $urandom_range(0, 3);
      1: return S_MIN + $urandom_range(0, 3);
      2: return $urandom_range(0, 1024) - 512;
      3: return $urandom_range(0, 2) - 1;
      4: return ($urandom_range(0, 1) ? 32'd1 : -32'sd1) <<< $urandom_range(0, 30);
      default: return $urandom;
    endcase
  endfunction

  // Present one request on the falling edge and hold it until it is taken.
  task automatic send_request(input logic [3:0] op, input logic [31:0] a,
                              input logic [31:0] b, input bit known,
                              input alu_out_t answer);
    alu_out_t model;
    model = alu_predict(op, a, b);
    if (known && model !== answer) begin
      $error("table row %0d disagrees with model: %h vs %h", sent, answer, model);
      errors++;
    end
    start <= 1'b1;
    req_type <= op;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
    pending_results.push_back(known ? answer : model);
    sent++;
    @(negedge clk);
  endtask

  task automatic idle_for(input int n);
    start <= 1'b0;
    req_type <= 4'($urandom);
    operand_a <= $urandom;
    operand_b <= $urandom;
    repeat (n) @(negedge clk);
  endtask

  // Results are compared as they appear; the oldest expectation is consumed.
  always @(posedge clk) begin
    alu_out_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %h", result);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        checked++;
        if (result !== exp_r.value) begin
          $error("result: expected %h, got %h", exp_r.value, result);
          errors++;
        end
        if (a_greater !== exp_r.gt) begin
          $error("a_greater: expected %b, got %b", exp_r.gt, a_greater);
          errors++;
        end
        if (a_less !== exp_r.lt) begin
          $error("a_less: expected %b, got %b", exp_r.lt, a_less);
          errors++;
        end
        if (a_equal !== exp_r.eq) begin
          $error("a_equal: expected %b, got %b", exp_r.eq, a_equal);
          errors++;
        end
        if (overflow !== exp_r.ovf) begin
          $error("overflow: expected %b, got %b", exp_r.ovf, overflow);
          errors++;
        end
        if (divide_by_zero !== exp_r.dbz) begin
          $error("divide_by_zero: expected %b, got %b", exp_r.dbz, divide_by_zero);
          errors++;
        end
      end
    end
  end

  // Watchdog: the slowest legal run is far below this.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    vec_t rows[$];
    int burst;
    logic [3:0] op;
    errors = 0;
    checked = 0;
    cycles = 0;
    sent = 0;
    rst = 1'b1;
    start = 1'b0;
    req_type = '0;
    operand_a = '0;
    operand_b = '0;

    // Directed table. Answers are typed in for saturation, division by zero,
    // the compare, ties, conversions, unused selectors; others use the model.
    rows = '{
      '{fxalu_pkg::OP_ADD, S_MAX, 32'd1, 1'b1,
        '{S_MAX, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{fxalu_pkg::OP_ADD, S_MIN, S_MIN, 1'b1,
        '{S_MIN, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
      '{fxalu_pkg::OP_SUB, S_MIN, 32'd1, 1'b1,
        '{S_MIN, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{fxalu_pkg::OP_SUB, S_MAX, S_MIN, 1'b1,
        '{S_MAX, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{fxalu_pkg::OP_MUL, 32'h0000_0180, 32'h0000_0280, 1'b0, '0},
      '{fxalu_pkg::OP_MUL, 32'h0000_0001, 32'h0000_0080, 1'b1,
        '{32'd1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{fxalu_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0000_0080, 1'b1,
        '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{fxalu_pkg::OP_MUL, S_MIN, S_MIN, 1'b1,
        '{S_MAX, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
      '{fxalu_pkg::OP_MUL, S_MAX, S_MIN, 1'b1,
        '{S_MIN, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{fxalu_pkg::OP_DIV, 32'h0000_0100, 32'd0, 1'b1,
        '{32'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{fxalu_pkg::OP_DIV, S_MIN, 32'd0, 1'b1,
        '{32'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{fxalu_pkg::OP_DIV, S_MIN, 32'd1, 1'b1,
        '{S_MIN, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{fxalu_pkg::OP_DIV, 32'h0000_0100, 32'h0000_0300, 1'b0, '0},
      '{fxalu_pkg::OP_DIV, 32'hFFFF_FF00, 32'h0000_0200, 1'b0, '0},
      '{fxalu_pkg::OP_DIV, S_MAX, S_MAX, 1'b0, '0},
      '{fxalu_pkg::OP_MIN, S_MIN, S_MAX, 1'b0, '0},
      '{fxalu_pkg::OP_MAX, S_MIN, S_MAX, 1'b0, '0},
      '{fxalu_pkg::OP_INC, S_MAX, 32'd0, 1'b1,
        '{S_MAX, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{fxalu_pkg::OP_DEC, S_MIN, 32'd0, 1'b1,
        '{S_MIN, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{fxalu_pkg::OP_CMP, 32'd5, 32'd5, 1'b1,
        '{32'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
      '{fxalu_pkg::OP_TOINT, S_MIN, 32'd0, 1'b1,
        '{32'hFF80_0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{fxalu_pkg::OP_TOINT, 32'hFFFF_FFFF, 32'd0, 1'b1,
        '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{fxalu_pkg::OP_FROMINT, 32'h0080_0000, 32'd0, 1'b1,
        '{S_MAX, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{fxalu_pkg::OP_FROMINT, 32'hFF80_0000, 32'd0, 1'b1,
        '{S_MIN, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{4'd15, S_MAX, S_MIN, 1'b1, '{32'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_request(rows[i].op, rows[i].a, rows[i].b,
                                   rows[i].known, rows[i].answer);

    // Random requests in bursts, with gaps of random length between them;
    // some bursts run back to back so that the full rate is exercised.
    while (sent < N_RANDOM + rows.size()) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                          : 4'($urandom_range(0, 10));
        send_request(op, pick_operand(), pick_operand(), 1'b0, '0);
      end
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
    end
    idle_for(1);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);

    $display("Sent %0d requests (all eleven operations, unused selectors,", sent);
    $display("saturation and divide by zero); %0d results checked.", checked);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
